// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the window-max RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, switched off while reset is asserted.
`define HWM_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent check on a clock, for logic that has no reset.
`define HWM_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/hwm_pkg.sv =====
// ---------------------------------------------------------------------------
// hwm_pkg
// Shared constants and types of the hourglass window maximum block.
// ---------------------------------------------------------------------------
`default_nettype none

package hwm_pkg;

    // Default sizes of the parameterized storage and sample path.
    localparam int MAX_COLS_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Seven sample terms need three more bits than one sample.
    localparam int SUM_GROWTH = 3;

    // Configuration register file.
    localparam int CFG_W      = 7;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLS = 1'b1;

    localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd6;

    // Control that travels with a sum into the reduce stage.
    typedef struct packed {
        logic valid;
        logic win_full;
        logic last;
    } hwm_stage_t;

endpackage

`default_nettype wire

// ===== src/hwm_line_ram.sv =====
// ---------------------------------------------------------------------------
// hwm_line_ram
// One-row line buffer: one write and one registered read port per cycle,
// with write-first forwarding when both ports hit the same entry.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hwm_line_ram #(
    parameter int DEPTH = hwm_pkg::MAX_COLS_DEF,
    parameter int WIDTH = hwm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; a write to the same entry is passed through.
    always_ff @(posedge aclk) begin
        if (we && (waddr == raddr)) begin
            rdata_reg <= wdata;
        end else begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

    `HWM_ASSERT_CLK(a_ram_forward, aclk, (we && (waddr == raddr)) |=> (rdata == $past(wdata)), "line buffer forwarding returned stale data")

endmodule

`default_nettype wire

// ===== src/hwm_front.sv =====
// ---------------------------------------------------------------------------
// hwm_front
// Input side: configuration registers, raster counters, line buffer access,
// the hourglass window and the seven-term sum stage.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hwm_front #(
    parameter int MAX_COLS    = hwm_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS = hwm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_we,
    input  wire logic [hwm_pkg::CFG_ADDR_W-1:0]          cfg_addr,
    input  wire logic [hwm_pkg::CFG_W-1:0]               cfg_wdata,
    input  wire logic                                    s_valid,
    input  wire logic signed [SAMPLE_BITS-1:0]           s_sample_value,
    input  wire logic                                    adv,
    output hwm_pkg::hwm_stage_t                          stage,
    output logic signed [SAMPLE_BITS+hwm_pkg::SUM_GROWTH-1:0] stage_sum
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CFG_W = hwm_pkg::CFG_W;
    localparam int SUM_W = SAMPLE_BITS + hwm_pkg::SUM_GROWTH;

    logic [CFG_W-1:0] grid_rows_reg;
    logic [CFG_W-1:0] grid_cols_reg;
    logic [CFG_W-1:0] row_count_reg;
    logic [COL_W-1:0] col_count_reg;

    logic [CFG_W-1:0] rows_eff;
    logic [COL_W:0]   cols_eff;
    logic             row_end;
    logic             frame_end;
    logic [COL_W-1:0] col_next;
    logic [COL_W-1:0] rd_addr;
    logic             fire;
    logic             win_full;

    logic signed [SAMPLE_BITS-1:0] up_q;
    logic signed [SAMPLE_BITS-1:0] mid_q;

    // Window columns that the hourglass still needs: index 0 is older.
    logic signed [SAMPLE_BITS-1:0] top_reg [2];
    logic signed [SAMPLE_BITS-1:0] ctr_reg;
    logic signed [SAMPLE_BITS-1:0] bot_reg [2];

    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] sum_reg;
    hwm_pkg::hwm_stage_t     stage_reg;

    assign fire = s_valid && adv;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= hwm_pkg::GRID_SIZE_RESET;
            grid_cols_reg <= hwm_pkg::GRID_SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                hwm_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_wdata;
                hwm_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the frame size: zero acts as one, oversize acts as the buffer size.
    always_comb begin
        if (grid_rows_reg == '0) begin
            rows_eff = CFG_W'(1);
        end else if (32'(grid_rows_reg) > MAX_COLS) begin
            rows_eff = CFG_W'(MAX_COLS);
        end else begin
            rows_eff = grid_rows_reg;
        end
        if (grid_cols_reg == '0) begin
            cols_eff = (COL_W+1)'(1);
        end else if (32'(grid_cols_reg) > MAX_COLS) begin
            cols_eff = (COL_W+1)'(MAX_COLS);
        end else begin
            cols_eff = (COL_W+1)'(grid_cols_reg);
        end
    end

    // Row and frame ends, and the column the next item will use.
    assign row_end   = (({1'b0, col_count_reg} + (COL_W+1)'(1)) >= cols_eff);
    assign frame_end = row_end &&
                       (({1'b0, row_count_reg} + (CFG_W+1)'(1)) >= {1'b0, rows_eff});
    assign col_next  = row_end ? '0 : col_count_reg + COL_W'(1);
    assign rd_addr   = fire ? col_next : col_count_reg;
    assign win_full  = (row_count_reg >= CFG_W'(2)) && (col_count_reg >= COL_W'(2));

    // Raster counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end else if (fire) begin
            col_count_reg <= col_next;
            if (frame_end) begin
                row_count_reg <= '0;
            end else if (row_end) begin
                row_count_reg <= row_count_reg + CFG_W'(1);
            end
        end
    end

    // Line buffers: the upper row takes the old middle row, the middle row
    // takes the new sample. Reads are registered, at the next item's column.
    hwm_line_ram #(
        .DEPTH (MAX_COLS),
        .WIDTH (SAMPLE_BITS)
    ) u_upper_ram (
        .aclk  (aclk),
        .we    (fire),
        .waddr (col_count_reg),
        .wdata (mid_q),
        .raddr (rd_addr),
        .rdata (up_q)
    );

    hwm_line_ram #(
        .DEPTH (MAX_COLS),
        .WIDTH (SAMPLE_BITS)
    ) u_middle_ram (
        .aclk  (aclk),
        .we    (fire),
        .waddr (col_count_reg),
        .wdata (s_sample_value),
        .raddr (rd_addr),
        .rdata (mid_q)
    );

    // Hourglass sum over the window as it stands after this item shifts in.
    assign sum_next = SUM_W'(top_reg[0]) + SUM_W'(top_reg[1]) + SUM_W'(up_q)
                    + SUM_W'(ctr_reg)
                    + SUM_W'(bot_reg[0]) + SUM_W'(bot_reg[1]) + SUM_W'(s_sample_value);

    // Window shift.
    always_ff @(posedge aclk) begin
        if (fire) begin
            top_reg[0] <= top_reg[1];
            top_reg[1] <= up_q;
            ctr_reg    <= mid_q;
            bot_reg[0] <= bot_reg[1];
            bot_reg[1] <= s_sample_value;
        end
    end

    // Sum stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
        end else if (adv) begin
            stage_reg.valid    <= fire;
            stage_reg.win_full <= win_full;
            stage_reg.last     <= frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            sum_reg <= sum_next;
        end
    end

    assign stage     = stage_reg;
    assign stage_sum = sum_reg;

    `HWM_ASSERT_RST(a_front_no_early_sum, aclk, aresetn, (fire && (row_count_reg < CFG_W'(2))) |=> !stage_reg.win_full, "hourglass sum flagged in the first two rows")

endmodule

`default_nettype wire

// ===== src/hwm_reduce.sv =====
// ---------------------------------------------------------------------------
// hwm_reduce
// Running maximum of the hourglass sums and the result output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hwm_reduce #(
    parameter int SAMPLE_BITS = hwm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire hwm_pkg::hwm_stage_t                           stage,
    input  wire logic signed [SAMPLE_BITS+hwm_pkg::SUM_GROWTH-1:0] stage_sum,
    output logic                                               adv,
    output logic                                               m_valid,
    input  wire logic                                          m_ready,
    output logic signed [SAMPLE_BITS+hwm_pkg::SUM_GROWTH-1:0]  m_max_sum,
    output logic                                               m_found
);

    localparam int SUM_W = SAMPLE_BITS + hwm_pkg::SUM_GROWTH;

    logic signed [SUM_W-1:0] best_reg;
    logic signed [SUM_W-1:0] best_next;
    logic                    have_reg;
    logic                    have_next;
    logic                    out_valid_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic                    out_found_reg;
    logic                    b_fire;

    // The pipeline moves unless a frame result waits on a full output register.
    assign adv    = !(stage.valid && stage.last && out_valid_reg && !m_ready);
    assign b_fire = stage.valid && adv;

    // Candidate update: the first window seeds, later ones must be larger.
    always_comb begin
        best_next = best_reg;
        have_next = have_reg;
        if (b_fire && stage.win_full && (!have_reg || (stage_sum > best_reg))) begin
            best_next = stage_sum;
            have_next = 1'b1;
        end
    end

    // Running maximum, cleared at the end of each frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (b_fire && stage.last) begin
            have_reg <= 1'b0;
        end else begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg <= best_next;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (b_fire && stage.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire && stage.last) begin
            out_sum_reg   <= have_next ? best_next : '0;
            out_found_reg <= have_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_max_sum = out_sum_reg;
    assign m_found   = out_found_reg;

    `HWM_ASSERT_RST(a_red_result_loaded, aclk, aresetn, (b_fire && stage.last) |=> (out_valid_reg && !have_reg), "frame end did not load a result and clear the maximum")
    `HWM_ASSERT_RST(a_red_stall_cause, aclk, aresetn, !adv |-> (stage.valid && stage.last && m_valid), "pipeline stalled without a waiting frame result")

endmodule

`default_nettype wire

// ===== src/hourglass_window_max_top.sv =====
// ---------------------------------------------------------------------------
// hourglass_window_max_top
// Largest hourglass sum over each raster-order frame of signed samples.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid / s_ready  s_sample_value
//   m_        out        m_valid / m_ready  m_max_sum, m_found
//   cfg_      in         cfg_we             cfg_addr, cfg_wdata
//
// One sample is accepted per clock while s_ready is high; the line buffers
// are read ahead of the item that uses them, so their single read port sets
// that rate. The frame result reaches the output register via the sum stage
// register. Input stalls only while a frame-end item waits on an untaken result.
// Reset clears counters, the maximum and the output; the line buffers are
// not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module hourglass_window_max_top #(
    parameter int MAX_COLS    = hwm_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_BITS = hwm_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire logic                                          cfg_we,
    input  wire logic [hwm_pkg::CFG_ADDR_W-1:0]                cfg_addr,
    input  wire logic [hwm_pkg::CFG_W-1:0]                     cfg_wdata,
    input  wire logic                                          s_valid,
    output logic                                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]                 s_sample_value,
    output logic                                               m_valid,
    input  wire logic                                          m_ready,
    output logic signed [SAMPLE_BITS+hwm_pkg::SUM_GROWTH-1:0]  m_max_sum,
    output logic                                               m_found
);

    localparam int SUM_W = SAMPLE_BITS + hwm_pkg::SUM_GROWTH;

    hwm_pkg::hwm_stage_t     stage;
    logic signed [SUM_W-1:0] stage_sum;
    logic                    adv;

    // Window, line buffers and sum stage.
    hwm_front #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_sample_value (s_sample_value),
        .adv            (adv),
        .stage          (stage),
        .stage_sum      (stage_sum)
    );

    // Running maximum and result register.
    hwm_reduce #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stage     (stage),
        .stage_sum (stage_sum),
        .adv       (adv),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_max_sum (m_max_sum),
        .m_found   (m_found)
    );

    assign s_ready = adv;

endmodule

`default_nettype wire
